// ===== design/fecs_pkg.sv =====
`default_nettype none

package fecs_pkg;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_REPAIR  = 2'd0,
    OP_SOURCE  = 2'd1,
    OP_PAYLOAD = 2'd2
  } op_t;

  // Kind of work queued between front and back.
  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_ERROR  = 2'd1,
    CMD_BYTE   = 2'd2
  } cmd_kind_t;

  // Header segments in emission order.
  typedef enum logic [2:0] {
    SEG_TYPE   = 3'd0,
    SEG_BLOCK  = 3'd1,
    SEG_SYMBOL = 3'd2,
    SEG_COUNT  = 3'd3,
    SEG_SCHEME = 3'd4,
    SEG_LENGTH = 3'd5
  } seg_t;

  localparam int unsigned TYPE_W = 62;

  // Configuration register indexes.
  localparam logic CFG_REPAIR_TYPE = 1'b0;
  localparam logic CFG_SOURCE_TYPE = 1'b1;

  localparam logic [TYPE_W-1:0] REPAIR_TYPE_RESET = 62'd64512;
  localparam logic [TYPE_W-1:0] SOURCE_TYPE_RESET = 62'd64513;

  // Varint range limits and first-byte length prefixes.
  localparam logic [TYPE_W-1:0] VARINT_MAX1 = 62'd63;
  localparam logic [TYPE_W-1:0] VARINT_MAX2 = 62'd16383;
  localparam logic [TYPE_W-1:0] VARINT_MAX4 = 62'd1073741823;
  localparam logic [7:0] PREFIX_1 = 8'h00;
  localparam logic [7:0] PREFIX_2 = 8'h40;
  localparam logic [7:0] PREFIX_4 = 8'h80;
  localparam logic [7:0] PREFIX_8 = 8'hc0;

  // Single-byte header fields: symbol, count and scheme on a repair header,
  // symbol and count on a source info header.
  localparam logic [4:0] FIXED_HDR_BYTES    = 5'd3;
  localparam logic [4:0] SOURCE_FIXED_BYTES = 5'd2;
  localparam logic [4:0] MAX_HDR_BYTES      = 5'd19;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              source;
    logic              hdr_last;
    logic [TYPE_W-1:0] type_val;
    logic [1:0]        type_code;
    logic [31:0]       block;
    logic [1:0]        block_code;
    logic [7:0]        symbol;
    logic [7:0]        count;
    logic [7:0]        scheme;
    logic [15:0]       length;
    logic [1:0]        length_code;
    logic [7:0]        data;
    logic              data_last;
  } cmd_t;

  // Size code of a varint: 0, 1, 2, 3 for 1, 2, 4, 8 bytes.
  function automatic logic [1:0] varint_code(input logic [TYPE_W-1:0] v);
    logic [1:0] code;
    if (v <= VARINT_MAX1) code = 2'd0;
    else if (v <= VARINT_MAX2) code = 2'd1;
    else if (v <= VARINT_MAX4) code = 2'd2;
    else code = 2'd3;
    return code;
  endfunction

  function automatic logic [3:0] varint_bytes(input logic [1:0] code);
    logic [3:0] n;
    case (code)
      2'd0: n = 4'd1;
      2'd1: n = 4'd2;
      2'd2: n = 4'd4;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] varint_prefix(input logic [1:0] code);
    logic [7:0] p;
    case (code)
      2'd0: p = PREFIX_1;
      2'd1: p = PREFIX_2;
      2'd2: p = PREFIX_4;
      default: p = PREFIX_8;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== design/fecs_front.sv =====
`default_nettype none

module fecs_front #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    operation,
  input  wire logic [31:0]                   block_num,
  input  wire logic [7:0]                    symbol_num,
  input  wire logic [7:0]                    count,
  input  wire logic [7:0]                    scheme,
  input  wire logic [15:0]                   data_length,
  input  wire logic [15:0]                   space,
  input  wire logic [7:0]                    data_byte,
  input  wire logic [fecs_pkg::TYPE_W-1:0]   repair_type,
  input  wire logic [fecs_pkg::TYPE_W-1:0]   source_type,
  input  wire logic                          q_full,
  output logic                               q_push,
  output fecs_pkg::cmd_t                     q_din
);

  localparam logic [15:0] LenMask =
    (LENGTH_BITS >= 16) ? 16'hFFFF : 16'((33'd1 << LENGTH_BITS) - 33'd1);

  logic [LENGTH_BITS-1:0] payload_remaining;
  logic [LENGTH_BITS-1:0] payload_remaining_next;
  logic                   accept;
  logic                   repair_op;
  logic [15:0]            dlen;
  logic [4:0]             hdr_bytes;
  logic [16:0]            total;
  logic                   no_fit;
  fecs_pkg::op_t          op;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign op        = fecs_pkg::op_t'(operation);
  assign repair_op = (op == fecs_pkg::OP_REPAIR);
  assign dlen      = repair_op ? (data_length & LenMask) : 16'd0;

  always_comb begin
    q_din             = '0;
    q_din.kind        = fecs_pkg::CMD_BYTE;
    q_din.source      = !repair_op;
    q_din.hdr_last    = (dlen == 16'd0);
    q_din.type_val    = repair_op ? repair_type : source_type;
    q_din.type_code   = fecs_pkg::varint_code(q_din.type_val);
    q_din.block       = block_num;
    q_din.block_code  = fecs_pkg::varint_code(62'(block_num));
    q_din.symbol      = symbol_num;
    q_din.count       = count;
    q_din.scheme      = scheme;
    q_din.length      = dlen;
    q_din.length_code = fecs_pkg::varint_code(62'(dlen));
    q_din.data        = data_byte;
    q_din.data_last   = (payload_remaining == LENGTH_BITS'(1));

    hdr_bytes = 5'(fecs_pkg::varint_bytes(q_din.type_code))
              + 5'(fecs_pkg::varint_bytes(q_din.block_code))
              + (repair_op ? fecs_pkg::FIXED_HDR_BYTES : fecs_pkg::SOURCE_FIXED_BYTES);
    if (repair_op) begin
      hdr_bytes = hdr_bytes + 5'(fecs_pkg::varint_bytes(q_din.length_code));
    end
    total  = 17'(hdr_bytes) + 17'(dlen);
    no_fit = (total > 17'(space)) || (hdr_bytes > fecs_pkg::MAX_HDR_BYTES);

    q_push                 = 1'b0;
    payload_remaining_next = payload_remaining;
    case (op)
      fecs_pkg::OP_PAYLOAD: begin
        if (payload_remaining != '0) begin
          q_push = accept;
          if (accept) begin
            payload_remaining_next = payload_remaining - LENGTH_BITS'(1);
          end
        end
      end
      fecs_pkg::OP_REPAIR, fecs_pkg::OP_SOURCE: begin
        q_push     = accept;
        q_din.kind = no_fit ? fecs_pkg::CMD_ERROR : fecs_pkg::CMD_HEADER;
        if (accept) begin
          // a new header drops whatever payload was still due
          payload_remaining_next = no_fit ? '0 : LENGTH_BITS'(dlen);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_remaining <= '0;
    end else begin
      payload_remaining <= payload_remaining_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/fecs_queue.sv =====
`default_nettype none

module fecs_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire fecs_pkg::cmd_t din,
  output logic                full,
  input  wire logic           pop,
  output fecs_pkg::cmd_t      dout,
  output logic                valid
);

  fecs_pkg::cmd_t                         entries [fecs_pkg::QUEUE_DEPTH];
  logic [fecs_pkg::QUEUE_PTR_W-1:0]       wr_ptr;
  logic [fecs_pkg::QUEUE_PTR_W-1:0]       rd_ptr;
  logic [fecs_pkg::QUEUE_CNT_W-1:0]       fill;

  assign full  = (fill == fecs_pkg::QUEUE_CNT_W'(fecs_pkg::QUEUE_DEPTH));
  assign valid = (fill != '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + fecs_pkg::QUEUE_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + fecs_pkg::QUEUE_PTR_W'(1);
      fill <= fill + fecs_pkg::QUEUE_CNT_W'(push) - fecs_pkg::QUEUE_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== design/fecs_back.sv =====
`default_nettype none

module fecs_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire fecs_pkg::cmd_t q_dout,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                out_status
);

  fecs_pkg::seg_t seg;
  fecs_pkg::seg_t seg_next;
  logic [2:0]     idx;
  logic [2:0]     idx_next;
  logic           load;
  logic [63:0]    seg_val;
  logic [1:0]     seg_code;
  logic [2:0]     seg_last_idx;
  logic [2:0]     shift;
  logic           seg_done;
  logic           entry_done;
  fecs_pkg::seg_t final_seg;
  logic [7:0]     byte_sel;
  logic           last_sel;
  logic           status_sel;

  assign load  = q_valid && (!out_valid || out_ready);
  assign q_pop = load && entry_done;

  // Segment selection and entry progress.
  always_comb begin
    case (seg)
      fecs_pkg::SEG_TYPE:   begin seg_val = {2'b0, q_dout.type_val}; seg_code = q_dout.type_code;   end
      fecs_pkg::SEG_BLOCK:  begin seg_val = {32'b0, q_dout.block};   seg_code = q_dout.block_code;  end
      fecs_pkg::SEG_SYMBOL: begin seg_val = {56'b0, q_dout.symbol};  seg_code = 2'd0;               end
      fecs_pkg::SEG_COUNT:  begin seg_val = {56'b0, q_dout.count};   seg_code = 2'd0;               end
      fecs_pkg::SEG_SCHEME: begin seg_val = {56'b0, q_dout.scheme};  seg_code = 2'd0;               end
      fecs_pkg::SEG_LENGTH: begin seg_val = {48'b0, q_dout.length};  seg_code = q_dout.length_code; end
      default:              begin seg_val = '0;                      seg_code = 2'd0;               end
    endcase
    seg_last_idx = 3'(fecs_pkg::varint_bytes(seg_code) - 4'd1);
    shift        = seg_last_idx - idx;
    seg_done     = (idx == seg_last_idx);
    final_seg    = q_dout.source ? fecs_pkg::SEG_COUNT : fecs_pkg::SEG_LENGTH;
    entry_done   = (q_dout.kind != fecs_pkg::CMD_HEADER) || (seg_done && seg == final_seg);
  end

  // Next position in the header.
  always_comb begin
    seg_next = seg;
    idx_next = idx;
    if (load) begin
      if (entry_done) begin
        seg_next = fecs_pkg::SEG_TYPE;
        idx_next = 3'd0;
      end else if (seg_done) begin
        idx_next = 3'd0;
        case (seg)
          fecs_pkg::SEG_TYPE:   seg_next = fecs_pkg::SEG_BLOCK;
          fecs_pkg::SEG_BLOCK:  seg_next = fecs_pkg::SEG_SYMBOL;
          fecs_pkg::SEG_SYMBOL: seg_next = fecs_pkg::SEG_COUNT;
          fecs_pkg::SEG_COUNT:  seg_next = fecs_pkg::SEG_SCHEME;
          fecs_pkg::SEG_SCHEME: seg_next = fecs_pkg::SEG_LENGTH;
          default:              seg_next = fecs_pkg::SEG_TYPE;
        endcase
      end else begin
        idx_next = idx + 3'd1;
      end
    end
  end

  // Output word for the current position.
  always_comb begin
    byte_sel   = seg_val[{shift, 3'b000} +: 8];
    if (idx == 3'd0) begin
      byte_sel = byte_sel | fecs_pkg::varint_prefix(seg_code);
    end
    last_sel   = entry_done && q_dout.hdr_last;
    status_sel = 1'b0;
    case (q_dout.kind)
      fecs_pkg::CMD_ERROR: begin
        byte_sel   = 8'd0;
        last_sel   = 1'b1;
        status_sel = 1'b1;
      end
      fecs_pkg::CMD_BYTE: begin
        byte_sel = q_dout.data;
        last_sel = q_dout.data_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg       <= fecs_pkg::SEG_TYPE;
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      seg <= seg_next;
      idx <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= byte_sel;
      out_last   <= last_sel;
      out_status <= status_sel;
    end
  end

endmodule

`default_nettype wire

// ===== design/fec_frame_serializer.sv =====
// FEC frame serializer: turns frame requests into a byte stream of QUIC-style
// varints (1, 2, 4 or 8 bytes).
// Slave stream: one word per request. tuser carries the operation (repair
// header, source info, payload byte); tdata carries the request fields.
// Master stream: one word per output byte, tlast on the final byte of a frame
// and on an error word, tuser set on an error word (frame does not fit, data 0).
// Config port: cfg_we/cfg_index/cfg_data write the repair and source-info
// frame type registers; write only while the block is idle.
// Path: an accepted request word is written into the queue; the back end then
// loads its first output byte from the queue head into the output register.
// Throughput: a payload byte or error yields one output word; a header yields
// one output word per header byte (4 to 19). The back end emits one byte per cycle
// while the receiver takes it, which sets the rate; the front end keeps accepting
// words while the two-entry queue has room, so payload words stream at one per cycle.
// Reset: clears the payload counter, queue, sequencer and output valid, and
// restores the frame type registers to their defaults.
// A stalled receiver holds the output word; the queue then fills and tready
// drops until the back end drains it.
`default_nettype none

module fec_frame_serializer #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [fecs_pkg::TYPE_W-1:0]  cfg_data,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // block_num[31:0], symbol_num[39:32], count[47:40], scheme[55:48],
  // data_length[71:56], space[87:72], data_byte[95:88]
  input  wire logic [95:0]                  s_tdata,
  // operation[1:0]
  input  wire logic [1:0]                   s_tuser,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // out_byte[7:0]
  output logic [7:0]                        m_tdata,
  output logic                              m_tlast,
  // status[0]
  output logic                              m_tuser
);

  logic [fecs_pkg::TYPE_W-1:0] repair_frame_type;
  logic [fecs_pkg::TYPE_W-1:0] source_info_frame_type;

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  fecs_pkg::cmd_t q_din;
  fecs_pkg::cmd_t q_dout;

  // Frame type registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      repair_frame_type      <= fecs_pkg::REPAIR_TYPE_RESET;
      source_info_frame_type <= fecs_pkg::SOURCE_TYPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fecs_pkg::CFG_REPAIR_TYPE: repair_frame_type      <= cfg_data;
        fecs_pkg::CFG_SOURCE_TYPE: source_info_frame_type <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: accept a word, track the payload still due, size the header
  // and decide whether the frame fits.
  fecs_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .operation   (s_tuser),
    .block_num   (s_tdata[31:0]),
    .symbol_num  (s_tdata[39:32]),
    .count       (s_tdata[47:40]),
    .scheme      (s_tdata[55:48]),
    .data_length (s_tdata[71:56]),
    .space       (s_tdata[87:72]),
    .data_byte   (s_tdata[95:88]),
    .repair_type (repair_frame_type),
    .source_type (source_info_frame_type),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_din       (q_din)
  );

  // Short queue decoupling the front from the byte sequencer.
  fecs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid)
  );

  // Back: walk each queued entry out one byte per cycle, while the receiver takes bytes, into the output register.
  fecs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_dout     (q_dout),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_last   (m_tlast),
    .out_status (m_tuser)
  );

  // Never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue push while full");

  // Never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

  // An error word is always a zero byte that closes the frame.
  a_error_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'd0))
    else $error("malformed error word");

endmodule

`default_nettype wire

// ===== tb/fec_stream_checker.sv =====
`timescale 1ns / 100ps

module fec_stream_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [fecs_pkg::TYPE_W-1:0] cfg_data,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  // block_num, symbol_num, count, scheme, data_length, space, data_byte
  input  logic [95:0]                 s_tdata,
  // operation
  input  logic [1:0]                  s_tuser,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  // out_byte
  input  logic [7:0]                  m_tdata,
  input  logic                        m_tlast,
  // status
  input  logic                        m_tuser,
  output int                          fail_count,
  output int                          bytes_due,
  output int                          bytes_checked,
  output int                          refusals
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       refused;
  } out_word_t;

  out_word_t                   due_q[$];
  logic [7:0]                  hdr_q[$];
  logic [fecs_pkg::TYPE_W-1:0] repair_type;
  logic [fecs_pkg::TYPE_W-1:0] source_type;
  logic [15:0]                 payload_left;
  int                          mismatches;
  int                          checked;
  int                          refused_frames;

  function automatic void put_varint(input logic [fecs_pkg::TYPE_W-1:0] v);
    int                          len;
    int                          i;
    logic [7:0]                  pre;
    logic [fecs_pkg::TYPE_W-1:0] shifted;
    if (v <= fecs_pkg::VARINT_MAX1) begin
      len = 1;
      pre = fecs_pkg::PREFIX_1;
    end else if (v <= fecs_pkg::VARINT_MAX2) begin
      len = 2;
      pre = fecs_pkg::PREFIX_2;
    end else if (v <= fecs_pkg::VARINT_MAX4) begin
      len = 4;
      pre = fecs_pkg::PREFIX_4;
    end else begin
      len = 8;
      pre = fecs_pkg::PREFIX_8;
    end
    for (i = 0; i < len; i++) begin
      shifted = v >> (8 * (len - 1 - i));
      hdr_q.push_back((i == 0) ? (shifted[7:0] | pre) : shifted[7:0]);
    end
  endfunction

  // Work out the bytes one request word produces and queue them.
  function automatic void serialize_word(input logic [1:0] op, input logic [95:0] d);
    logic [31:0] blk;
    logic [15:0] dlen;
    logic [15:0] space;
    int          total;
    int          k;
    blk   = d[31:0];
    dlen  = d[71:56];
    space = d[87:72];
    case (op)
      fecs_pkg::OP_PAYLOAD: begin
        if (payload_left != '0) begin
          payload_left = payload_left - 16'd1;
          due_q.push_back(out_word_t'{d[95:88], payload_left == '0, 1'b0});
        end
      end
      fecs_pkg::OP_REPAIR, fecs_pkg::OP_SOURCE: begin
        hdr_q.delete();
        put_varint((op == fecs_pkg::OP_REPAIR) ? repair_type : source_type);
        put_varint({{(fecs_pkg::TYPE_W-32){1'b0}}, blk});
        hdr_q.push_back(d[39:32]);
        hdr_q.push_back(d[47:40]);
        if (op == fecs_pkg::OP_REPAIR) begin
          hdr_q.push_back(d[55:48]);
          put_varint({{(fecs_pkg::TYPE_W-16){1'b0}}, dlen});
        end else begin
          dlen = '0;
        end
        total = hdr_q.size() + int'(dlen);
        if (total > int'(space) || hdr_q.size() > int'(fecs_pkg::MAX_HDR_BYTES)) begin
          payload_left = '0;
          refused_frames++;
          due_q.push_back(out_word_t'{8'h00, 1'b1, 1'b1});
        end else begin
          payload_left = dlen;
          for (k = 0; k < hdr_q.size(); k++)
            due_q.push_back(out_word_t'{hdr_q[k],
                                        k == hdr_q.size() - 1 && dlen == '0, 1'b0});
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    out_word_t w;
    if (rst) begin
      repair_type    = fecs_pkg::REPAIR_TYPE_RESET;
      source_type    = fecs_pkg::SOURCE_TYPE_RESET;
      payload_left   = '0;
      mismatches     = 0;
      checked        = 0;
      refused_frames = 0;
      due_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        checked++;
        if (due_q.size() == 0) begin
          $error("unexpected output word: out_byte %0h last %0b status %0b",
                 m_tdata, m_tlast, m_tuser);
          mismatches++;
        end else begin
          w = due_q.pop_front();
          if (m_tdata !== w.data) begin
            $error("out_byte: expected %0h, got %0h", w.data, m_tdata);
            mismatches++;
          end
          if (m_tlast !== w.last) begin
            $error("last: expected %0b, got %0b", w.last, m_tlast);
            mismatches++;
          end
          if (m_tuser !== w.refused) begin
            $error("status: expected %0b, got %0b", w.refused, m_tuser);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == fecs_pkg::CFG_REPAIR_TYPE) repair_type = cfg_data;
        else source_type = cfg_data;
      end
      if (s_tvalid && s_tready) serialize_word(s_tuser, s_tdata);
    end
    fail_count    <= mismatches;
    bytes_due     <= due_q.size();
    bytes_checked <= checked;
    refusals      <= refused_frames;
  end

endmodule

// ===== tb/tb_fec_frame_serializer.sv =====
`timescale 1ns / 100ps

module tb_fec_frame_serializer;

  // Operation code the block must ignore.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam int HOLD_CYCLES     = 200;  // receiver hold-off used to back up the input
  localparam int SETTLE_CYCLES   = 8;    // settling margin once no output word is still due
  localparam int ITEMS_PER_PHASE = 23;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        cfg_we    = 1'b0;
  logic                        cfg_index = 1'b0;
  logic [fecs_pkg::TYPE_W-1:0] cfg_data  = '0;
  logic                        s_tvalid  = 1'b0;
  logic                        s_tready;
  // block_num, symbol_num, count, scheme, data_length, space, data_byte
  logic [95:0]                 s_tdata   = '0;
  // operation
  logic [1:0]                  s_tuser   = '0;
  logic                        m_tvalid;
  logic                        m_tready  = 1'b0;
  // out_byte
  logic [7:0]                  m_tdata;
  logic                        m_tlast;
  // status
  logic                        m_tuser;

  int fail_count;
  int bytes_due;
  int bytes_checked;
  int refusals;

  int send_idle_pct = 36;
  int recv_idle_pct = 78;
  int words_sent    = 0;
  int hold_requests = 0;
  int holds_done    = 0;

  always #5 clk = ~clk;

  fec_frame_serializer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // Predict and compare every output word next to the block.
  fec_stream_checker monitor (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser),
    .fail_count    (fail_count),
    .bytes_due     (bytes_due),
    .bytes_checked (bytes_checked),
    .refusals      (refusals)
  );

  // Watchdog: give up long after the slowest legal run would have finished.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Receiver: stall at random, or hold off for a long stretch on request so
  // the internal queue fills and the block drops s_tready.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one word, idling first at random; return at the edge that takes it.
  task automatic send_word(input logic [1:0] op, input logic [31:0] blk,
                           input logic [7:0] sym, input logic [7:0] cnt,
                           input logic [7:0] sch, input logic [15:0] dlen,
                           input logic [15:0] space, input logic [7:0] dbyte);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {dbyte, space, dlen, sch, cnt, sym, blk};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  // Header words carry a random data_byte so its bits toggle even when unused.
  task automatic repair(input logic [31:0] blk, input logic [7:0] sym, input logic [7:0] cnt,
                        input logic [7:0] sch, input logic [15:0] dlen,
                        input logic [15:0] space);
    send_word(fecs_pkg::OP_REPAIR, blk, sym, cnt, sch, dlen, space, 8'($urandom));
  endtask

  // Source info ignores scheme and data_length; drive noise there.
  task automatic source(input logic [31:0] blk, input logic [7:0] sym, input logic [7:0] cnt,
                        input logic [15:0] space);
    send_word(fecs_pkg::OP_SOURCE, blk, sym, cnt, 8'($urandom), 16'($urandom), space,
              8'($urandom));
  endtask

  task automatic payload(input logic [7:0] b);
    send_word(fecs_pkg::OP_PAYLOAD, $urandom, 8'($urandom), 8'($urandom), 8'($urandom),
              16'($urandom), 16'($urandom), b);
  endtask

  // Stop offering and wait until every predicted word has come out.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both frame type registers; call only while the block is idle.
  task automatic set_types(input logic [fecs_pkg::TYPE_W-1:0] rep,
                           input logic [fecs_pkg::TYPE_W-1:0] src);
    cfg_we    <= 1'b1;
    cfg_index <= fecs_pkg::CFG_REPAIR_TYPE;
    cfg_data  <= rep;
    @(posedge clk);
    cfg_index <= fecs_pkg::CFG_SOURCE_TYPE;
    cfg_data  <= src;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Block ids spread over every varint size, plus the size boundaries.
  function automatic logic [31:0] pick_block();
    logic [31:0] v;
    case ($urandom_range(5))
      0: v = $urandom_range(63);
      1: v = $urandom_range(16383, 64);
      2: v = $urandom_range(1073741823, 16384);
      3: v = $urandom_range(32'hffff_ffff, 32'h4000_0000);
      4: v = $urandom;
      default: begin
        case ($urandom_range(7))
          0: v = 32'd0;
          1: v = 32'd63;
          2: v = 32'd64;
          3: v = 32'd16383;
          4: v = 32'd16384;
          5: v = 32'd1073741823;
          6: v = 32'd1073741824;
          default: v = 32'hffff_ffff;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [fecs_pkg::TYPE_W-1:0] pick_type();
    logic [fecs_pkg::TYPE_W-1:0] v;
    case ($urandom_range(3))
      0: v = fecs_pkg::TYPE_W'($urandom_range(63));
      1: v = fecs_pkg::TYPE_W'($urandom_range(16383, 64));
      2: v = fecs_pkg::TYPE_W'($urandom_range(1073741823, 16384));
      default: v = fecs_pkg::TYPE_W'({$urandom, $urandom})
                 | fecs_pkg::TYPE_W'(32'h4000_0000);
    endcase
    return v;
  endfunction

  // Mostly short payloads; now and then a long one that a later header cuts.
  function automatic logic [15:0] pick_length();
    logic [15:0] v;
    case ($urandom_range(9))
      0: v = 16'($urandom_range(16383, 64));
      1: v = 16'($urandom);
      default: v = 16'($urandom_range(6));
    endcase
    return v;
  endfunction

  // Small budgets straddle the fit boundary; the full 16-bit budget still refuses near-maximum payloads.
  function automatic logic [15:0] pick_space();
    logic [15:0] v;
    case ($urandom_range(19))
      0, 1, 2: v = 16'($urandom);
      3, 4, 5, 6, 7, 8, 9: v = 16'($urandom_range(32));
      default: v = 16'hffff;
    endcase
    return v;
  endfunction

  // One random frame: a repair header with its payload, a source info word,
  // or noise (a stray payload byte or the reserved operation).
  task automatic random_frame();
    int          r;
    int          n;
    int          k;
    logic [15:0] dlen;
    r = $urandom_range(99);
    if (r < 60) begin
      dlen = pick_length();
      repair(pick_block(), 8'($urandom), 8'($urandom), 8'($urandom), dlen, pick_space());
      if (dlen <= 16'd6) n = int'(dlen);
      else n = $urandom_range(4);
      // Cut the payload short now and then; the next header drops the rest.
      if (n > 0 && $urandom_range(4) == 0) n = $urandom_range(n - 1);
      for (k = 0; k < n; k++) payload(8'($urandom));
    end else if (r < 85) begin
      source(pick_block(), 8'($urandom), 8'($urandom), pick_space());
    end else if (r < 93) begin
      payload(8'($urandom));
    end else begin
      send_word(OP_RESERVED, $urandom, 8'($urandom), 8'($urandom), 8'($urandom),
                16'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic random_run(input int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) random_frame();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on the reset frame types (both encode as 4-byte varints).
    repair(32'd0, 8'h00, 8'h00, 8'h00, 16'd0, 16'hffff);           // empty payload
    repair(32'hffff_ffff, 8'hff, 8'hff, 8'hff, 16'd2, 16'hffff);
    payload(8'h00);
    payload(8'hff);                                                 // last payload byte
    payload(8'ha5);                                                 // nothing due: dropped
    send_word(OP_RESERVED, 32'hffff_ffff, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff, 8'hff);
    source(32'd64, 8'h01, 8'h02, 16'd8);                            // fits exactly
    source(32'd64, 8'h01, 8'h02, 16'd7);                            // one byte short
    repair(32'd63, 8'h10, 8'h20, 8'h30, 16'd5, 16'd14);             // fits exactly
    payload(8'h11);
    payload(8'h22);
    source(32'd16383, 8'h40, 8'h50, 16'hffff);                      // cuts the payload
    payload(8'h33);
    repair(32'd16384, 8'h5a, 8'ha5, 8'h3c, 16'd1, 16'd12);          // one byte short
    payload(8'h44);
    repair(32'd1073741823, 8'h01, 8'h02, 8'h03, 16'd16383, 16'hffff);
    payload(8'h55);
    repair(32'd1073741824, 8'h04, 8'h05, 8'h06, 16'hffff, 16'hffff); // payload too long
    payload(8'h66);
    quiesce();

    // Widest repair type, smallest source type: hit the 19-byte header and
    // the headers that can never fit.
    set_types({fecs_pkg::TYPE_W{1'b1}}, '0);
    repair(32'd1073741823, 8'h81, 8'h82, 8'h83, 16'd16384, 16'hffff); // 19 header bytes
    payload(8'h77);
    repair(32'd1073741824, 8'h84, 8'h85, 8'h86, 16'd16384, 16'hffff); // oversized header
    source(32'd0, 8'haa, 8'h55, 16'd4);                              // fits exactly
    repair(32'd1073741824, 8'h87, 8'h88, 8'h89, 16'd0, 16'd0);
    quiesce();

    // Sender idles less than the receiver.
    set_types(pick_type(), pick_type());
    send_idle_pct = 36;
    recv_idle_pct = 78;
    random_run(ITEMS_PER_PHASE);
    quiesce();

    // Swap the idle rates; pause halfway until the output has fully drained.
    set_types(pick_type(), pick_type());
    send_idle_pct = 78;
    recv_idle_pct = 36;
    random_run(ITEMS_PER_PHASE / 2);
    quiesce();
    random_run(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
    quiesce();

    // No idling at all; hold the receiver off while a payload streams in
    // so the queue fills and the input stalls.
    set_types(fecs_pkg::TYPE_W'(fecs_pkg::VARINT_MAX1),
              fecs_pkg::TYPE_W'(fecs_pkg::VARINT_MAX4) + fecs_pkg::TYPE_W'(1));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    repair(pick_block(), 8'($urandom), 8'($urandom), 8'($urandom), 16'd16, 16'hffff);
    repeat (16) payload(8'($urandom));
    random_run(ITEMS_PER_PHASE);
    quiesce();

    $display("Run covered %0d request words over five frame-type settings and three idle mixes,",
             words_sent);
    $display("including a long receiver hold-off; %0d output words checked, %0d frames refused.",
             bytes_checked, refusals);
    if (fail_count == 0 && bytes_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
